@@ hdl/dmc_pkg.sv @@
// dmc_pkg: shared types and constants for the depth-first maze carver
// used by dmc_ctrl, dmc_datapath and dfs_maze_carver; no dependencies
package dmc_pkg;

  localparam int unsigned MAX_SIDE_DEF = 64;

  localparam int unsigned CFG_DW = 7;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned START_W = 6;
  localparam int unsigned RND_W = 8;
  localparam int unsigned OUT_CW = 6;

  localparam logic [CFG_IW-1:0] CFG_MAZE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAZE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_START_X     = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_START_Y     = 2'd3;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_STEP    = 1'b1;

  localparam int unsigned CFG_WIDTH_RST  = 64;
  localparam int unsigned CFG_HEIGHT_RST = 64;

  typedef enum logic [1:0] {
    KIND_CARVED     = 2'd0,
    KIND_BACKTRACK  = 2'd1,
    KIND_FINISHED   = 2'd2,
    KIND_RESTARTED  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RDA,
    ST_RDB,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic capture;
    logic sel_south;
    logic commit;
  } dmc_cmd_t;

  typedef struct packed {
    logic stack_empty;
    logic clear_last;
    logic out_free;
  } dmc_stat_t;

endpackage

@@ hdl/dmc_ctrl.sv @@
// dmc_ctrl: sequencer for restart, clear pass, neighbor reads and result commit
// depends on dmc_pkg; drives dmc_datapath through dmc_cmd_t
module dmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  dmc_pkg::dmc_stat_t  stat_i,
  output dmc_pkg::dmc_cmd_t   ctrl_o
);

  dmc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          if (cmd_i == dmc_pkg::CMD_RESTART) begin
            state_d = dmc_pkg::ST_CLEAR;
          end else if (stat_i.stack_empty) begin
            state_d = dmc_pkg::ST_EMIT;
          end else begin
            state_d = dmc_pkg::ST_RDA;
          end
        end
      end
      dmc_pkg::ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = dmc_pkg::ST_EMIT;
        end
      end
      dmc_pkg::ST_RDA: begin
        state_d = dmc_pkg::ST_RDB;
      end
      dmc_pkg::ST_RDB: begin
        ctrl_o.capture   = 1'b1;
        ctrl_o.sel_south = 1'b1;
        state_d          = dmc_pkg::ST_EMIT;
      end
      dmc_pkg::ST_EMIT: begin
        ctrl_o.sel_south = 1'b1;
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = dmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/dmc_datapath.sv @@
// dmc_datapath: config registers, visited row memory, path stack and result register
// depends on dmc_pkg; sequenced by dmc_ctrl
module dmc_datapath #(
  parameter int unsigned MAX_SIDE = dmc_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmc_pkg::CFG_IW-1:0]    cfg_index_i,
  input  logic [dmc_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          cmd_i,
  input  logic [dmc_pkg::RND_W-1:0]     random_value_i,
  input  dmc_pkg::dmc_cmd_t             ctrl_i,
  output dmc_pkg::dmc_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [dmc_pkg::OUT_CW-1:0]    cell_x_o,
  output logic [dmc_pkg::OUT_CW-1:0]    cell_y_o,
  output logic [1:0]                    direction_o
);

  localparam int unsigned CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned EW    = (CW + 1 > dmc_pkg::CFG_DW) ? CW + 1 : dmc_pkg::CFG_DW;
  localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);

  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s4;
    logic [2:0] s3;
    s4 = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
    s3 = {1'b0, s4[3:2]} + {1'b0, s4[1:0]};
    if (s3 >= 3'd3) s3 = s3 - 3'd3;
    if (s3 >= 3'd3) s3 = s3 - 3'd3;
    return s3[1:0];
  endfunction

  // configuration
  logic [dmc_pkg::CFG_DW-1:0]  width_q, height_q;
  logic [dmc_pkg::START_W-1:0] start_x_q, start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= dmc_pkg::CFG_DW'(dmc_pkg::CFG_WIDTH_RST);
      height_q  <= dmc_pkg::CFG_DW'(dmc_pkg::CFG_HEIGHT_RST);
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dmc_pkg::CFG_MAZE_WIDTH:  width_q   <= cfg_data_i;
        dmc_pkg::CFG_MAZE_HEIGHT: height_q  <= cfg_data_i;
        dmc_pkg::CFG_START_X:     start_x_q <= cfg_data_i[dmc_pkg::START_W-1:0];
        dmc_pkg::CFG_START_Y:     start_y_q <= cfg_data_i[dmc_pkg::START_W-1:0];
      endcase
    end
  end

  logic [EW-1:0] w_cfg, h_cfg, w_eff, h_eff, sx_e, sy_e;
  logic [CW-1:0] sx, sy;

  always_comb begin
    w_cfg = EW'(width_q);
    h_cfg = EW'(height_q);
    w_eff = (w_cfg == '0) ? EW'(1) : ((w_cfg > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : w_cfg);
    h_eff = (h_cfg == '0) ? EW'(1) : ((h_cfg > EW'(MAX_SIDE)) ? EW'(MAX_SIDE) : h_cfg);
    sx_e  = EW'(start_x_q);
    sy_e  = EW'(start_y_q);
    if (sx_e > w_eff - EW'(1)) sx_e = w_eff - EW'(1);
    if (sy_e > h_eff - EW'(1)) sy_e = h_eff - EW'(1);
    sx = CW'(sx_e);
    sy = CW'(sy_e);
  end

  // latched transaction
  logic                      cmd_q;
  logic [dmc_pkg::RND_W-1:0] rnd_q;
  logic [CW-1:0]             clr_cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      rnd_q <= random_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.load) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clear) begin
      clr_cnt_q <= clr_cnt_q + CW'(1);
    end
  end

  // path stack
  logic [2*CW-1:0] stk_mem [CELLS];
  logic [2*CW-1:0] top_q;
  logic [CNTW-1:0] count_q;
  logic [AW-1:0]   top_addr, push_addr;
  logic            stack_empty, stack_room;
  logic [CW-1:0]   x, y;

  assign stack_empty = (count_q == '0);
  assign stack_room  = (count_q < CNTW'(CELLS));
  assign top_addr    = stack_empty ? '0 : AW'(count_q - CNTW'(1));
  assign push_addr   = AW'(count_q);
  assign x           = top_q[CW-1:0];
  assign y           = top_q[2*CW-1:CW];

  // visited map, one row of cells per entry
  logic [MAX_SIDE-1:0] vis_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] rd0_q, rd1_q, clr_row;
  logic [CW-1:0]       rd0_addr, rd1_addr;

  assign rd0_addr = y - CW'(1);
  assign rd1_addr = ctrl_i.sel_south ? y + CW'(1) : y;
  assign clr_row  = (clr_cnt_q == sy) ? (MAX_SIDE'(1) << sx) : '0;

  // neighbor checks
  logic [EW-1:0] xe, ye;
  logic [CW-1:0] xp1, xm1;
  logic          in_x, in_y, n_ok, e_ok, w_ok, s_ok;
  logic          n_q, e_q, w_q;

  always_comb begin
    xe   = EW'(x);
    ye   = EW'(y);
    xp1  = x + CW'(1);
    xm1  = x - CW'(1);
    in_x = (xe < w_eff);
    in_y = (ye < h_eff);
    n_ok = (y != '0) && in_x && (ye - EW'(1) < h_eff) && !rd0_q[x];
    e_ok = (xe + EW'(1) < w_eff) && in_y && !rd1_q[xp1];
    w_ok = (x != '0) && (xe - EW'(1) < w_eff) && in_y && !rd1_q[xm1];
    s_ok = in_x && (ye + EW'(1) < h_eff) && !rd1_q[x];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      n_q <= n_ok;
      e_q <= e_ok;
      w_q <= w_ok;
    end
  end

  // candidate choice
  logic [3:0]     mask;
  logic [2:0]     n_cand;
  logic [1:0]     k, seen;
  logic           found;
  dmc_pkg::dir_e  pick;
  logic [CW-1:0]  tx, ty;
  logic           is_restart, carve;
  dmc_pkg::kind_e kind_d;

  always_comb begin
    mask   = {w_q, s_ok, e_q, n_q};
    n_cand = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]} + {2'b00, mask[3]};
    unique case (n_cand)
      3'd2:    k = {1'b0, rnd_q[0]};
      3'd3:    k = mod3(rnd_q);
      3'd4:    k = rnd_q[1:0];
      default: k = 2'd0;
    endcase
    pick  = dmc_pkg::DIR_NORTH;
    seen  = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i] && !found) begin
        if (seen == k) begin
          pick  = dmc_pkg::dir_e'(2'(i));
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    tx = x;
    ty = y;
    unique case (pick)
      dmc_pkg::DIR_NORTH: ty = y - CW'(1);
      dmc_pkg::DIR_EAST:  tx = xp1;
      dmc_pkg::DIR_SOUTH: ty = y + CW'(1);
      dmc_pkg::DIR_WEST:  tx = xm1;
    endcase
    is_restart = (cmd_q == dmc_pkg::CMD_RESTART);
    carve      = ctrl_i.commit && !is_restart && !stack_empty && (mask != 4'd0);
    if (is_restart) begin
      kind_d = dmc_pkg::KIND_RESTARTED;
    end else if (stack_empty) begin
      kind_d = dmc_pkg::KIND_FINISHED;
    end else if (mask == 4'd0) begin
      kind_d = dmc_pkg::KIND_BACKTRACK;
    end else begin
      kind_d = dmc_pkg::KIND_CARVED;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      vis_mem[clr_cnt_q] <= clr_row;
    end else if (carve) begin
      vis_mem[ty][tx] <= 1'b1;
    end
    rd0_q <= vis_mem[rd0_addr];
    rd1_q <= vis_mem[rd1_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && is_restart) begin
      stk_mem[0] <= {sy, sx};
    end else if (carve && stack_room) begin
      stk_mem[push_addr] <= {ty, tx};
    end
    top_q <= stk_mem[top_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.commit) begin
      if (is_restart) begin
        count_q <= CNTW'(1);
      end else if (carve) begin
        if (stack_room) count_q <= count_q + CNTW'(1);
      end else if (!stack_empty) begin
        count_q <= count_q - CNTW'(1);
      end
    end
  end

  // result register
  logic                       out_valid_q;
  dmc_pkg::kind_e             kind_q;
  dmc_pkg::dir_e              dir_q;
  logic [dmc_pkg::OUT_CW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      kind_q <= kind_d;
      dir_q  <= (kind_d == dmc_pkg::KIND_CARVED) ? pick : dmc_pkg::DIR_NORTH;
      if (is_restart) begin
        cx_q <= dmc_pkg::OUT_CW'(sx);
        cy_q <= dmc_pkg::OUT_CW'(sy);
      end else if (stack_empty) begin
        cx_q <= '0;
        cy_q <= '0;
      end else begin
        cx_q <= dmc_pkg::OUT_CW'(x);
        cy_q <= dmc_pkg::OUT_CW'(y);
      end
    end
  end

  assign stat_o.stack_empty = stack_empty;
  assign stat_o.clear_last  = (clr_cnt_q == CW'(MAX_SIDE - 1));
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign cell_x_o    = cx_q;
  assign cell_y_o    = cy_q;
  assign direction_o = dir_q;

endmodule

@@ hdl/dfs_maze_carver.sv @@
// dfs_maze_carver: depth-first backtracking maze carver, top level
// depends on dmc_pkg, dmc_ctrl and dmc_datapath
//
// usage: a command transaction on the input channel (cmd_i, random_value_i)
// gives exactly one result transaction (kind_o, cell_x_o, cell_y_o, direction_o).
// a restart command clears the visited map one row per cycle, all MAX_SIDE
// rows, then pushes the clamped start cell at its commit. a step command
// reads the stack top, then the visited rows above, at and below the top
// cell over a two-port row memory, and commits the carve or pop. a step on
// an empty stack skips the row reads and reports finished. one command is
// in flight at a time: a new command is accepted only once the last one
// has committed its result to the output register.
// the result sits in an output register; while the receiver stalls, the
// finished transaction waits there and a following command is accepted and
// worked on up to its commit, which waits for the register to free.
// reset empties the stack and loads the default configuration; a step before any
// restart reports finished. the user must write configuration through cfg_we_i,
// cfg_index_i, cfg_data_i only while no command is in flight (not enforced).
module dfs_maze_carver #(
  parameter int unsigned MAX_SIDE = dmc_pkg::MAX_SIDE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dmc_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [dmc_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [dmc_pkg::RND_W-1:0]   random_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic [dmc_pkg::OUT_CW-1:0]  cell_x_o,
  output logic [dmc_pkg::OUT_CW-1:0]  cell_y_o,
  output logic [1:0]                  direction_o
);

  dmc_pkg::dmc_cmd_t  ctrl;
  dmc_pkg::dmc_stat_t stat;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  dmc_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .random_value_i (random_value_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .cell_x_o       (cell_x_o),
    .cell_y_o       (cell_y_o),
    .direction_o    (direction_o)
  );

endmodule
